FILE: design/mkd_pkg.sv
`default_nettype none
package mkd_pkg;

	localparam int unsigned SampleW   = 8;
	localparam int unsigned TicksW    = 16;
	localparam int unsigned KeyW      = 5;
	localparam int unsigned ValueW    = 9;
	localparam int unsigned CmdW      = 3;
	localparam int unsigned ProdW     = 12;

	localparam logic [SampleW-1:0] DRIVE_IDLE  = 8'hF0;
	localparam logic [TicksW-1:0]  TICKS_RESET = 16'd10;
	localparam logic [ValueW-1:0]  VALUE_MAX   = 9'd256;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT    = 3'd1,
		PH_CONFIRM = 3'd2,
		PH_COL0    = 3'd3,
		PH_COL1    = 3'd4,
		PH_COL2    = 3'd5,
		PH_COL3    = 3'd6
	} phase_t;

	typedef enum logic [CmdW-1:0] {
		CMD_NONE     = 3'd0,
		CMD_DIGIT    = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_RETRAIN  = 3'd3,
		CMD_DOWNLOAD = 3'd4,
		CMD_UPLOAD   = 3'd5,
		CMD_SEND     = 3'd6
	} cmd_t;

	localparam logic [KeyW-1:0] KEY_STOP     = 5'd4;
	localparam logic [KeyW-1:0] KEY_RETRAIN  = 5'd8;
	localparam logic [KeyW-1:0] KEY_DOWNLOAD = 5'd12;
	localparam logic [KeyW-1:0] KEY_UPLOAD   = 5'd13;
	localparam logic [KeyW-1:0] KEY_SEND     = 5'd16;

	typedef struct packed {
		logic [SampleW-1:0] drive;
		logic               done;
		logic [KeyW-1:0]    code;
		cmd_t               cmd;
		logic [ValueW-1:0]  value;
	} result_t;

	// column drive byte, column 0 is the leftmost
	function automatic logic [SampleW-1:0] col_drive(input logic [1:0] col);
		logic [SampleW-1:0] d;
		case (col)
			2'd0: d = 8'hF7;
			2'd1: d = 8'hFB;
			2'd2: d = 8'hFD;
			default: d = 8'hFE;
		endcase
		return d;
	endfunction

	// key 1..16 for a readback in a column, 0 when nothing matches
	function automatic logic [KeyW-1:0] match_key(input logic [1:0] col,
			input logic [SampleW-1:0] sample);
		logic [SampleW-1:0] drv;
		logic [KeyW-1:0]    base;
		drv = col_drive(col);
		case (sample[7:4])
			4'hE: base = 5'd13;
			4'hD: base = 5'd9;
			4'hB: base = 5'd5;
			4'h7: base = 5'd1;
			default: base = 5'd0;
		endcase
		if (sample[3:0] != drv[3:0] || base == 5'd0) begin
			return '0;
		end
		return base + {3'b000, col};
	endfunction

	// {is_digit, digit}
	function automatic logic [4:0] key_digit(input logic [KeyW-1:0] key);
		logic [4:0] r;
		case (key)
			5'd1:  r = {1'b1, 4'd1};
			5'd2:  r = {1'b1, 4'd2};
			5'd3:  r = {1'b1, 4'd3};
			5'd5:  r = {1'b1, 4'd4};
			5'd6:  r = {1'b1, 4'd5};
			5'd7:  r = {1'b1, 4'd6};
			5'd9:  r = {1'b1, 4'd7};
			5'd10: r = {1'b1, 4'd8};
			5'd11: r = {1'b1, 4'd9};
			5'd14: r = {1'b1, 4'd0};
			default: r = {1'b0, 4'd0};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/mkd_scan.sv
`default_nettype none
module mkd_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [mkd_pkg::SampleW-1:0]  sample,
	input  wire logic [mkd_pkg::TicksW-1:0]   debounce_ticks,
	output mkd_pkg::result_t                  res
);
	import mkd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TicksW-1:0]   wait_q, wait_d;
	logic [KeyW-1:0]     pend_q, pend_d;
	logic [ValueW-1:0]   value_q, value_d;

	logic [1:0]          col_sel;
	logic [KeyW-1:0]     col_key;
	logic [TicksW-1:0]   wait_dec;
	logic [4:0]          dig;
	logic [ProdW-1:0]    acc;

	always_comb begin
		case (phase_q)
			PH_COL1: col_sel = 2'd1;
			PH_COL2: col_sel = 2'd2;
			PH_COL3: col_sel = 2'd3;
			default: col_sel = 2'd0;
		endcase
	end

	assign col_key  = match_key(col_sel, sample);
	assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		pend_d    = pend_q;
		value_d   = value_q;
		res.drive = DRIVE_IDLE;
		res.done  = 1'b0;
		res.code  = '0;
		res.cmd   = CMD_NONE;
		case (phase_q)
			PH_WAIT: begin
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					phase_d = PH_CONFIRM;
				end
			end
			PH_CONFIRM: begin
				if (sample == DRIVE_IDLE) begin
					phase_d = PH_IDLE;
				end else begin
					pend_d    = '0;
					res.drive = col_drive(2'd0);
					phase_d   = PH_COL0;
				end
			end
			PH_COL0, PH_COL1, PH_COL2: begin
				if (col_key != '0) begin
					pend_d = col_key;
				end
				res.drive = col_drive(col_sel + 2'd1);
				phase_d   = phase_t'(phase_q + 3'd1);
			end
			PH_COL3: begin
				res.done = 1'b1;
				res.code = (col_key != '0) ? col_key : pend_q;
				phase_d  = PH_IDLE;
				pend_d   = '0;
			end
			default: begin
				// idle detect, also any stray phase code
				if (sample != DRIVE_IDLE) begin
					wait_d  = debounce_ticks;
					phase_d = (debounce_ticks == '0) ? PH_CONFIRM : PH_WAIT;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase

		// key action
		dig       = key_digit(res.code);
		acc       = {3'b000, value_q} * 12'd10 + {8'h00, dig[3:0]};
		res.value = value_q;
		if (res.done) begin
			if (dig[4]) begin
				res.cmd   = CMD_DIGIT;
				value_d   = (acc > {3'b000, VALUE_MAX}) ? '0 : acc[ValueW-1:0];
				res.value = value_d;
			end else if (res.code == KEY_STOP) begin
				res.cmd = CMD_STOP;
			end else if (res.code == KEY_RETRAIN) begin
				res.cmd = CMD_RETRAIN;
			end else if (res.code == KEY_DOWNLOAD) begin
				res.cmd = CMD_DOWNLOAD;
			end else if (res.code == KEY_UPLOAD) begin
				res.cmd = CMD_UPLOAD;
			end else if (res.code == KEY_SEND) begin
				res.cmd = CMD_SEND;
				value_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			pend_q  <= '0;
			value_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			pend_q  <= pend_d;
			value_q <= value_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/matrix_keypad_scan_decimal_entry_core.sv
// 4x4 matrix keypad scanner with decimal entry. Each input transfer carries
// one readback of the keypad port; each output transfer carries the drive
// byte to apply before the next sample (F0 while idle or debouncing; F7 once
// confirmed, then FB, FD, FE while walking the columns) plus the scan result.
// A press is seen when the readback leaves F0, then debounce_ticks samples
// are skipped and one more sample confirms it; four column samples follow
// and the last one finishes the scan with key_done high. Digit keys build a
// decimal value (value*10+digit, wrapping to 0 above 256); keys 4, 8, 12, 13
// and 16 raise commands, and key 16 shows the value and then clears it.
// Exactly one output transfer follows every input transfer, in order.
// Timing: an accepted sample sits in an input register, the scan step runs
// there and writes the output register, and one sample can be taken every
// cycle while the output is not stalled. While a result waits to be taken,
// the input register can still take a sample if it is empty. debounce_ticks
// is written through cfg_wr_en/cfg_wr_data and should only change while the
// block is idle; it resets to 10.
`default_nettype none
module matrix_keypad_scan_decimal_entry_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mkd_pkg::TicksW-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mkd_pkg::SampleW-1:0]   port_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mkd_pkg::SampleW-1:0]        drive_pattern,
	output logic                               key_done,
	output logic [mkd_pkg::KeyW-1:0]           key_code,
	output logic [mkd_pkg::CmdW-1:0]           command,
	output logic [mkd_pkg::ValueW-1:0]         entered_value
);
	import mkd_pkg::*;

	logic [TicksW-1:0]  ticks_q;
	logic               vld_s1;
	logic [SampleW-1:0] sample_s1;
	logic               vld_s2;
	result_t            res_s2;
	result_t            res;
	logic               adv;

	// stage 1 moves on when the output slot is empty or being drained
	assign adv      = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= port_sample;
		end
		if (adv && vld_s1) begin
			res_s2 <= res;
		end
	end

	// scan state only steps when the stage 1 item is handed on
	mkd_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv && vld_s1),
		.sample         (sample_s1),
		.debounce_ticks (ticks_q),
		.res            (res)
	);

	assign out_valid     = vld_s2;
	assign drive_pattern = res_s2.drive;
	assign key_done      = res_s2.done;
	assign key_code      = res_s2.code;
	assign command       = res_s2.cmd;
	assign entered_value = res_s2.value;

endmodule
`default_nettype wire
